// ===== rtl/core/agdf_pkg.sv =====
// shared constants and types for the adaptive gain distance filter
`default_nettype none

package agdf_pkg;

  localparam int CHANNELS = 4;
  localparam int CH_W = 2;
  localparam int SAMPLE_W = 16;
  localparam int FILT_W = 24;
  localparam int FRAC_W = 8;
  localparam int GAIN_W = 17;
  localparam int DENOM_W = 17;
  localparam int DIFF_W = 25;
  localparam int ACC_W = 43;
  localparam int PROD_W = ACC_W - 16;
  localparam int NEXT_W = 28;
  localparam int CNT_W = 5;

  localparam logic [CNT_W-1:0] GAIN_STEPS = CNT_W'(GAIN_W);
  localparam logic [FILT_W-1:0] FILT_MAX = {FILT_W{1'b1}};

  localparam logic [SAMPLE_W-1:0] LIMIT_RESET = 16'd100;
  localparam logic [SAMPLE_W-1:0] EST_RESET = 16'd50;

  localparam logic REG_DISTANCE_LIMIT = 1'b0;
  localparam logic REG_ESTIMATE_ERROR = 1'b1;

  // operands handed to the serial gain and multiply unit
  typedef struct packed {
    logic [DENOM_W-1:0] denom;
    logic [SAMPLE_W-1:0] est;
    logic signed [DIFF_W-1:0] diff;
  } agdf_job_t;

  // write of one channel's state
  typedef struct packed {
    logic we;
    logic [CH_W-1:0] ch;
    logic [FILT_W-1:0] filt;
    logic [SAMPLE_W-1:0] sample;
  } agdf_wr_t;

endpackage

`default_nettype wire

// ===== rtl/core/agdf_chan_store.sv =====
// per-channel filtered value and last sample registers
`default_nettype none

module agdf_chan_store import agdf_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [CH_W-1:0]     rd_ch_i,
  output logic      [FILT_W-1:0]   rd_filt_o,
  output logic      [SAMPLE_W-1:0] rd_last_o,
  input  wire agdf_wr_t            wr_i
);

  logic [FILT_W-1:0]   filt_q [CHANNELS];
  logic [SAMPLE_W-1:0] last_q [CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        filt_q[i] <= '0;
        last_q[i] <= '0;
      end
    end else if (wr_i.we) begin
      filt_q[wr_i.ch] <= wr_i.filt;
      last_q[wr_i.ch] <= wr_i.sample;
    end
  end

  assign rd_filt_o = filt_q[rd_ch_i];
  assign rd_last_o = last_q[rd_ch_i];

endmodule

`default_nettype wire

// ===== rtl/core/agdf_gain_mac.sv =====
// bit-serial gain divider fused with a horner multiply by the difference
`default_nettype none

module agdf_gain_mac import agdf_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire agdf_job_t                job_i,
  output logic                          done_o,
  output logic signed [PROD_W-1:0]      prod_o
);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [DENOM_W-1:0]        rem_q, rem_d;
  logic [DENOM_W-1:0]        dvd_q, dvd_d;
  logic [DENOM_W-1:0]        denom_q, denom_d;
  logic signed [DIFF_W-1:0]  diff_q, diff_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;

  logic [DENOM_W:0]          trial;
  logic                      qbit;
  logic signed [ACC_W-1:0]   addend;

  // quotient bits come out msb first, so they feed the multiply directly
  assign trial  = {rem_q, dvd_q[DENOM_W-1]};
  assign qbit   = trial >= {1'b0, denom_q};
  assign addend = qbit ? {{(ACC_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q} : '0;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    denom_d = denom_q;
    diff_d  = diff_q;
    acc_d   = acc_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = GAIN_STEPS;
      // top dividend bits already shifted in: est >> 1 is below the divisor whenever est is nonzero
      rem_d   = {1'b0, job_i.est[SAMPLE_W-1:1]};
      dvd_d   = {job_i.est[0], {(DENOM_W-1){1'b0}}};
      denom_d = job_i.denom;
      diff_d  = (job_i.est == '0) ? '0 : job_i.diff;
      acc_d   = '0;
    end else if (busy_q) begin
      rem_d = qbit ? DENOM_W'(trial - {1'b0, denom_q}) : trial[DENOM_W-1:0];
      dvd_d = {dvd_q[DENOM_W-2:0], 1'b0};
      acc_d = (acc_q <<< 1) + addend;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    dvd_q   <= dvd_d;
    denom_q <= denom_d;
    diff_q  <= diff_d;
    acc_q   <= acc_d;
  end

  assign done_o = done_q;
  // floor of product / 2^16
  assign prod_o = acc_q[ACC_W-1:ACC_W-PROD_W];

endmodule

`default_nettype wire

// ===== rtl/core/adaptive_gain_distance_filter_core.sv =====
// adaptive gain distance filter top level
// a zero sample is dropped and returns the core to idle with no result
// each word runs through the 17-step serial gain divider and multiply
// one word is in work at a time; a finished result waits in the output register
// reset: asynchronous active low, clears all channel state and restores both registers
`default_nettype none

module adaptive_gain_distance_filter_core import agdf_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_index_i,
  input  wire logic [SAMPLE_W-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [CH_W-1:0]     channel_i,
  input  wire logic [SAMPLE_W-1:0] raw_distance_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [CH_W-1:0]     out_channel_o,
  output logic      [FILT_W-1:0]   filtered_distance_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [SAMPLE_W-1:0] limit_q, est_q;
  logic [CH_W-1:0]     ch_q;
  logic [SAMPLE_W-1:0] smp_q, smp_d;
  logic                out_valid_q, out_valid_d;
  logic [CH_W-1:0]     out_ch_q;
  logic [FILT_W-1:0]   out_filt_q;

  logic                in_acc;
  logic [FILT_W-1:0]   rd_filt;
  logic [SAMPLE_W-1:0] rd_last;
  logic [SAMPLE_W-1:0] err;
  agdf_job_t           job;
  logic                start;
  logic                done;
  logic signed [PROD_W-1:0] prod;
  logic signed [NEXT_W-1:0] next_sum;
  logic [FILT_W-1:0]   next_filt;
  logic                out_load;
  agdf_wr_t            wr;

  assign in_stall_o = state_q != S_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign smp_d      = (raw_distance_i > limit_q) ? limit_q : raw_distance_i;

  agdf_chan_store u_store (
    .clk_i,
    .rst_ni,
    .rd_ch_i   (ch_q),
    .rd_filt_o (rd_filt),
    .rd_last_o (rd_last),
    .wr_i      (wr)
  );

  assign err       = (smp_q >= rd_last) ? smp_q - rd_last : rd_last - smp_q;
  assign job.denom = {1'b0, est_q} + {1'b0, err};
  assign job.est   = est_q;
  assign job.diff  = $signed({1'b0, smp_q, {FRAC_W{1'b0}}}) - $signed({1'b0, rd_filt});

  assign start = (state_q == S_PREP) && (smp_q != '0)
                 && (32'(ch_q) < 32'(CHANNELS));

  agdf_gain_mac u_mac (
    .clk_i,
    .rst_ni,
    .start_i (start),
    .job_i   (job),
    .done_o  (done),
    .prod_o  (prod)
  );

  assign next_sum = $signed({{(NEXT_W-FILT_W){1'b0}}, rd_filt})
                    + $signed({prod[PROD_W-1], prod});

  always_comb begin
    if (next_sum[NEXT_W-1]) begin
      next_filt = '0;
    end else if (next_sum[NEXT_W-2:FILT_W] != '0) begin
      next_filt = FILT_MAX;
    end else begin
      next_filt = next_sum[FILT_W-1:0];
    end
  end

  assign out_load  = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  assign wr.we     = out_load;
  assign wr.ch     = ch_q;
  assign wr.filt   = next_filt;
  assign wr.sample = smp_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_PREP;
      end
      S_PREP: begin
        state_d = start ? S_RUN : S_IDLE;
      end
      S_RUN: begin
        if (done) state_d = S_FIN;
      end
      S_FIN: begin
        if (out_load) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      limit_q     <= LIMIT_RESET;
      est_q       <= EST_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_DISTANCE_LIMIT: limit_q <= cfg_data_i;
          REG_ESTIMATE_ERROR: est_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q  <= channel_i;
      smp_q <= smp_d;
    end
    if (out_load) begin
      out_ch_q   <= ch_q;
      out_filt_q <= next_filt;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_channel_o       = out_ch_q;
  assign filtered_distance_o = out_filt_q;

endmodule

`default_nettype wire

// ===== rtl/core/agdf_checker.sv =====
// port-level checks for the adaptive gain distance filter
`default_nettype none

module agdf_checker import agdf_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                cfg_we_i,
  input wire logic                cfg_index_i,
  input wire logic [SAMPLE_W-1:0] cfg_data_i,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic [CH_W-1:0]     channel_i,
  input wire logic [SAMPLE_W-1:0] raw_distance_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [CH_W-1:0]     out_channel_o,
  input wire logic [FILT_W-1:0]   filtered_distance_o
);

  logic unused_ok;
  assign unused_ok = cfg_we_i ^ cfg_index_i ^ (^cfg_data_i) ^ (^channel_i)
                     ^ (^raw_distance_i);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(filtered_distance_o) && $stable(out_channel_o))
    else $error("stalled result changed");

  // one word in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after accept");

  // a new result only appears at the end of work on a word
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no word in work");

endmodule

bind adaptive_gain_distance_filter_core agdf_checker u_agdf_checker (.*);

`default_nettype wire
